// ----- rtl/core/gjk_pkg.sv -----
`default_nettype none

package gjk_pkg;

  // Fixed field widths of the channels
  localparam int PT_W   = 16;
  localparam int DIR_W  = 56;
  localparam int STAT_W = 2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_CONT = 2'd0,
    ST_SEP  = 2'd1,
    ST_HIT  = 2'd2,
    ST_NOQ  = 2'd3
  } status_t;

  // Simplex phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_LINE = 2'd2,
    PH_TRI  = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_t;

  // Jobs run on the shared multiply-accumulate unit
  typedef enum logic [3:0] {
    J_DOTSD,   // a . dir
    J_UU,      // u . u
    J_UV,      // u . ao
    J_TRI,     // dir = ao*uu - u*uv
    J_ABC,     // abc = ab x ac
    J_P1,      // p = ab x abc
    J_P2,      // p = abc x ac
    J_DOTP1,
    J_DOTP2,
    J_DOTABC,
    J_N1,      // n = ac x ad
    J_N2,      // n = ad x ab
    J_DOTN1,
    J_DOTN2
  } job_t;

  // Operand vector selects
  typedef enum logic [3:0] {
    V_AO,
    V_AB,
    V_AC,
    V_AD,
    V_U,
    V_ABC,
    V_N,
    V_P,
    V_DIR,
    V_UU,
    V_UV
  } vsel_t;

endpackage

`default_nettype wire

// ----- rtl/core/gjk_in_if.sv -----
`default_nettype none

interface gjk_in_if import gjk_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   start_query;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;

  modport source (output valid, start_query, point_x, point_y, point_z, input ready);
  modport sink   (input valid, start_query, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gjk_out_if.sv -----
`default_nettype none

interface gjk_out_if import gjk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic [STAT_W-1:0]       status;

  modport source (output valid, dir_x, dir_y, dir_z, status, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gjk_simplex_intersection.sv -----
`default_nettype none

// GJK overlap test, one Minkowski-difference support point per item. Each item
// must be the support along the last returned direction, or along (1,0,0)
// with start_query set. The result gives the next direction (exact integer,
// zero unless status is continue) and a status: continue, separated,
// intersecting or no query active. All products go through one shared
// multiplier (narrow operand times half of a 56-bit operand) feeding a 76-bit
// accumulator. A start item or an item with no query active runs no job; a
// point that proves separation runs one dot product job, and any other
// simplex step runs dot product, cross product and direction triple product
// jobs, as many as the simplex case needs. in_ready is high only while the
// sequencer is idle; a finished result waits in the output register while
// the next item is taken.
module gjk_simplex_intersection import gjk_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gjk_in_if.sink     in_ch,
  gjk_out_if.source  out_ch
);

  localparam int NW    = COORD_BITS + 1;     // point differences
  localparam int CW    = 2 * NW;             // cross of two differences
  localparam int PW    = 3 * NW;             // cross of difference and abc
  localparam int SW    = 2 * NW + 1;         // u.u and u.ao
  localparam int LO_W  = DIR_W / 2;          // split of the wide operand
  localparam int MW    = NW + LO_W + 1;      // multiplier product
  localparam int ACC_W = DIR_W + NW + 3;

  // Control
  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  phase_t phase_r, phase_nxt;
  status_t stat_r, stat_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic tri_ac_r, tri_ac_nxt;
  logic out_vld_r, out_vld_nxt;

  // Datapath
  logic signed [COORD_BITS-1:0] a_r[3], a_nxt[3];
  logic signed [COORD_BITS-1:0] sp1_r[3], sp1_nxt[3];
  logic signed [COORD_BITS-1:0] sp2_r[3], sp2_nxt[3];
  logic signed [COORD_BITS-1:0] sp3_r[3], sp3_nxt[3];
  logic signed [NW-1:0] ao_r[3], ao_nxt[3];
  logic signed [NW-1:0] ab_r[3], ab_nxt[3];
  logic signed [NW-1:0] ac_r[3], ac_nxt[3];
  logic signed [NW-1:0] ad_r[3], ad_nxt[3];
  logic signed [CW-1:0] abc_r[3], abc_nxt[3];
  logic signed [CW-1:0] n_r[3], n_nxt[3];
  logic signed [PW-1:0] p_r[3], p_nxt[3];
  logic signed [DIR_W-1:0] dir_r[3], dir_nxt[3];
  logic signed [SW-1:0] uu_r, uu_nxt, uv_r, uv_nxt;
  logic signed [MW-1:0] prod_r, prod_nxt;
  logic prod_vld_r, prod_vld_nxt, prod_first_r, prod_first_nxt;
  logic prod_hi_r, prod_hi_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [DIR_W-1:0] out_dir_r[3], out_dir_nxt[3];
  status_t out_stat_r, out_stat_nxt;

  // Operand select and helpers
  vsel_t a_sel, b_sel;
  logic [1:0] a_idx, b_idx, k1, k2, term;
  logic neg, is_dot, last_slot, acc_pos, acc_neg, go_job, do_keep;
  job_t new_job;
  logic signed [NW-1:0] a_val, a_op;
  logic signed [DIR_W-1:0] b_val;
  logic signed [LO_W:0] b_part;
  logic signed [COORD_BITS-1:0] a_in[3];
  logic signed [NW-1:0] ao_in[3];
  logic signed [ACC_W-1:0] prod_ext;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_vld_r;
  assign out_ch.dir_x  = out_dir_r[0];
  assign out_ch.dir_y  = out_dir_r[1];
  assign out_ch.dir_z  = out_dir_r[2];
  assign out_ch.status = out_stat_r;

  assign term    = slot_r[2:1];
  assign acc_neg = acc_r[ACC_W-1];
  assign acc_pos = !acc_r[ACC_W-1] && (acc_r != '0);

  // Input point, sign-extended from COORD_BITS
  always_comb begin
    a_in[0] = in_ch.point_x[COORD_BITS-1:0];
    a_in[1] = in_ch.point_y[COORD_BITS-1:0];
    a_in[2] = in_ch.point_z[COORD_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      ao_in[i] = -NW'(a_in[i]);
    end
  end

  // Cyclic component indexes for cross products
  always_comb begin
    unique case (comp_r)
      2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
      2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
      2'd2:    begin k1 = 2'd0; k2 = 2'd1; end
      default: begin k1 = 2'd0; k2 = 2'd0; end
    endcase
  end

  // Operand selection per job and term
  always_comb begin
    a_sel  = V_AO;
    b_sel  = V_DIR;
    a_idx  = term;
    b_idx  = term;
    neg    = 1'b0;
    is_dot = 1'b1;
    unique case (job_r)
      J_DOTSD:  begin b_sel = V_DIR; neg = 1'b1; end
      J_UU:     begin a_sel = V_U; b_sel = V_U; end
      J_UV:     b_sel = V_U;
      J_DOTP1, J_DOTP2: b_sel = V_P;
      J_DOTABC: b_sel = V_ABC;
      J_DOTN1, J_DOTN2: b_sel = V_N;
      J_TRI: begin
        is_dot = 1'b0;
        a_idx  = comp_r;
        if (term == 2'd0) begin
          a_sel = V_AO;
          b_sel = V_UU;
        end else begin
          a_sel = V_U;
          b_sel = V_UV;
          neg   = 1'b1;
        end
      end
      default: begin
        // cross products: a[k1]*b[k2] - a[k2]*b[k1], negated for J_P2
        is_dot = 1'b0;
        unique case (job_r)
          J_ABC:   begin a_sel = V_AB; b_sel = V_AC; end
          J_N1:    begin a_sel = V_AC; b_sel = V_AD; end
          J_N2:    begin a_sel = V_AD; b_sel = V_AB; end
          J_P1:    begin a_sel = V_AB; b_sel = V_ABC; end
          default: begin a_sel = V_AC; b_sel = V_ABC; end
        endcase
        if (term == 2'd0) begin
          a_idx = k1;
          b_idx = k2;
          neg   = (job_r == J_P2);
        end else begin
          a_idx = k2;
          b_idx = k1;
          neg   = (job_r != J_P2);
        end
      end
    endcase
    last_slot = is_dot ? (slot_r == 3'd5) : (slot_r == 3'd3);
  end

  // Operand muxes and the shared multiplier input
  always_comb begin
    unique case (a_sel)
      V_AO:    a_val = ao_r[a_idx];
      V_AB:    a_val = ab_r[a_idx];
      V_AC:    a_val = ac_r[a_idx];
      V_AD:    a_val = ad_r[a_idx];
      V_U:     a_val = tri_ac_r ? ac_r[a_idx] : ab_r[a_idx];
      default: a_val = '0;
    endcase
    unique case (b_sel)
      V_AB:    b_val = DIR_W'(ab_r[b_idx]);
      V_AC:    b_val = DIR_W'(ac_r[b_idx]);
      V_AD:    b_val = DIR_W'(ad_r[b_idx]);
      V_U:     b_val = tri_ac_r ? DIR_W'(ac_r[b_idx]) : DIR_W'(ab_r[b_idx]);
      V_ABC:   b_val = DIR_W'(abc_r[b_idx]);
      V_N:     b_val = DIR_W'(n_r[b_idx]);
      V_P:     b_val = DIR_W'(p_r[b_idx]);
      V_DIR:   b_val = dir_r[b_idx];
      V_UU:    b_val = DIR_W'(uu_r);
      V_UV:    b_val = DIR_W'(uv_r);
      default: b_val = '0;
    endcase
    a_op = neg ? -a_val : a_val;
    // low half unsigned, high half signed
    if (slot_r[0]) begin
      b_part = (LO_W + 1)'($signed(b_val[DIR_W-1:LO_W]));
    end else begin
      b_part = {1'b0, b_val[LO_W-1:0]};
    end
  end

  // Next state, sequencing and datapath updates
  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    phase_nxt      = phase_r;
    stat_nxt       = stat_r;
    comp_nxt       = comp_r;
    slot_nxt       = slot_r;
    tri_ac_nxt     = tri_ac_r;
    out_vld_nxt    = out_vld_r;
    out_stat_nxt   = out_stat_r;
    uu_nxt         = uu_r;
    uv_nxt         = uv_r;
    prod_nxt       = prod_r;
    prod_vld_nxt   = 1'b0;
    prod_first_nxt = prod_first_r;
    prod_hi_nxt    = prod_hi_r;
    go_job         = 1'b0;
    do_keep        = 1'b0;
    new_job        = job_r;
    for (int i = 0; i < 3; i++) begin
      a_nxt[i]       = a_r[i];
      sp1_nxt[i]     = sp1_r[i];
      sp2_nxt[i]     = sp2_r[i];
      sp3_nxt[i]     = sp3_r[i];
      ao_nxt[i]      = ao_r[i];
      ab_nxt[i]      = ab_r[i];
      ac_nxt[i]      = ac_r[i];
      ad_nxt[i]      = ad_r[i];
      abc_nxt[i]     = abc_r[i];
      n_nxt[i]       = n_r[i];
      p_nxt[i]       = p_r[i];
      dir_nxt[i]     = dir_r[i];
      out_dir_nxt[i] = out_dir_r[i];
    end

    // accumulate the registered product
    prod_ext = ACC_W'(prod_r);
    if (prod_hi_r) begin
      prod_ext = prod_ext <<< LO_W;
    end
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      acc_nxt = (prod_first_r ? '0 : acc_r) + prod_ext;
    end

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          for (int i = 0; i < 3; i++) begin
            a_nxt[i]  = a_in[i];
            ao_nxt[i] = ao_in[i];
            ab_nxt[i] = NW'(sp1_r[i]) - NW'(a_in[i]);
            ac_nxt[i] = NW'(sp2_r[i]) - NW'(a_in[i]);
            ad_nxt[i] = NW'(sp3_r[i]) - NW'(a_in[i]);
          end
          priority if (in_ch.start_query) begin
            state_nxt = S_DONE;
            if (a_in[0][COORD_BITS-1]) begin
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_SEP;
            end else begin
              for (int i = 0; i < 3; i++) begin
                sp2_nxt[i] = a_in[i];
                dir_nxt[i] = DIR_W'(ao_in[i]);
              end
              phase_nxt = PH_ONE;
              stat_nxt  = ST_CONT;
            end
          end else if (phase_r == PH_IDLE) begin
            state_nxt = S_DONE;
            stat_nxt  = ST_NOQ;
          end else begin
            go_job  = 1'b1;
            new_job = J_DOTSD;
          end
        end
      end

      S_ISSUE: begin
        prod_nxt       = a_op * b_part;
        prod_vld_nxt   = 1'b1;
        prod_first_nxt = (slot_r == 3'd0);
        prod_hi_nxt    = slot_r[0];
        slot_nxt       = slot_r + 3'd1;
        if (last_slot) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: state_nxt = S_COMMIT;

      S_COMMIT: begin
        unique case (job_r)
          J_DOTSD: begin
            priority if (acc_neg) begin
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_SEP;
              state_nxt = S_DONE;
            end else if (phase_r == PH_ONE) begin
              for (int i = 0; i < 3; i++) sp1_nxt[i] = a_r[i];
              tri_ac_nxt = 1'b1;
              go_job     = 1'b1;
              new_job    = J_UU;
            end else begin
              go_job  = 1'b1;
              new_job = J_ABC;
            end
          end
          J_UU: begin
            uu_nxt  = acc_r[SW-1:0];
            go_job  = 1'b1;
            new_job = J_UV;
          end
          J_UV: begin
            uv_nxt  = acc_r[SW-1:0];
            go_job  = 1'b1;
            new_job = J_TRI;
          end
          J_DOTP1: begin
            go_job = 1'b1;
            if (acc_pos) begin
              for (int i = 0; i < 3; i++) begin
                sp2_nxt[i] = sp1_r[i];
                sp1_nxt[i] = a_r[i];
              end
              tri_ac_nxt = 1'b0;
              new_job    = J_UU;
            end else begin
              new_job = J_P2;
            end
          end
          J_DOTP2: begin
            priority if (acc_pos) begin
              for (int i = 0; i < 3; i++) sp1_nxt[i] = a_r[i];
              tri_ac_nxt = 1'b1;
              go_job     = 1'b1;
              new_job    = J_UU;
            end else if (phase_r == PH_LINE) begin
              go_job  = 1'b1;
              new_job = J_DOTABC;
            end else begin
              do_keep = 1'b1;
            end
          end
          J_DOTABC: begin
            priority if (phase_r == PH_LINE) begin
              if (acc_pos) begin
                do_keep = 1'b1;
              end else begin
                // origin below the face: flip winding
                for (int i = 0; i < 3; i++) begin
                  sp3_nxt[i] = sp1_r[i];
                  sp1_nxt[i] = a_r[i];
                  dir_nxt[i] = -DIR_W'(abc_r[i]);
                end
                phase_nxt = PH_TRI;
                stat_nxt  = ST_CONT;
                state_nxt = S_DONE;
              end
            end else begin
              go_job  = 1'b1;
              new_job = acc_pos ? J_P1 : J_N1;
            end
          end
          J_DOTN1: begin
            go_job = 1'b1;
            if (acc_pos) begin
              for (int i = 0; i < 3; i++) begin
                sp1_nxt[i] = sp2_r[i];
                sp2_nxt[i] = sp3_r[i];
                ab_nxt[i]  = ac_r[i];
                ac_nxt[i]  = ad_r[i];
                abc_nxt[i] = n_r[i];
              end
              new_job = J_P1;
            end else begin
              new_job = J_N2;
            end
          end
          J_DOTN2: begin
            if (acc_pos) begin
              for (int i = 0; i < 3; i++) begin
                sp2_nxt[i] = sp1_r[i];
                sp1_nxt[i] = sp3_r[i];
                ac_nxt[i]  = ab_r[i];
                ab_nxt[i]  = ad_r[i];
                abc_nxt[i] = n_r[i];
              end
              go_job  = 1'b1;
              new_job = J_P1;
            end else begin
              // origin enclosed by the tetrahedron
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_HIT;
              state_nxt = S_DONE;
            end
          end
          default: begin
            // vector jobs: write one component, then the next
            unique case (job_r)
              J_TRI:        dir_nxt[comp_r] = acc_r[DIR_W-1:0];
              J_ABC:        abc_nxt[comp_r] = acc_r[CW-1:0];
              J_N1, J_N2:   n_nxt[comp_r]   = acc_r[CW-1:0];
              default:      p_nxt[comp_r]   = acc_r[PW-1:0];
            endcase
            if (comp_r != 2'd2) begin
              comp_nxt  = comp_r + 2'd1;
              slot_nxt  = '0;
              state_nxt = S_ISSUE;
            end else begin
              unique case (job_r)
                J_TRI: begin
                  phase_nxt = PH_LINE;
                  stat_nxt  = ST_CONT;
                  state_nxt = S_DONE;
                end
                J_ABC: begin
                  go_job  = 1'b1;
                  new_job = (phase_r == PH_LINE) ? J_P1 : J_DOTABC;
                end
                J_N1: begin
                  go_job  = 1'b1;
                  new_job = J_DOTN1;
                end
                J_N2: begin
                  go_job  = 1'b1;
                  new_job = J_DOTN2;
                end
                J_P1: begin
                  go_job  = 1'b1;
                  new_job = J_DOTP1;
                end
                default: begin
                  go_job  = 1'b1;
                  new_job = J_DOTP2;
                end
              endcase
            end
          end
        endcase
      end

      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_stat_nxt = stat_r;
          for (int i = 0; i < 3; i++) begin
            out_dir_nxt[i] = (stat_r == ST_CONT) ? dir_r[i] : '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // keep the face: shift the simplex, search along its normal
    if (do_keep) begin
      for (int i = 0; i < 3; i++) begin
        sp3_nxt[i] = sp2_r[i];
        sp2_nxt[i] = sp1_r[i];
        sp1_nxt[i] = a_r[i];
        dir_nxt[i] = DIR_W'(abc_r[i]);
      end
      phase_nxt = PH_TRI;
      stat_nxt  = ST_CONT;
      state_nxt = S_DONE;
    end

    // launch the next job
    if (go_job) begin
      job_nxt   = new_job;
      comp_nxt  = '0;
      slot_nxt  = '0;
      state_nxt = S_ISSUE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_IDLE;
      out_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      out_vld_r  <= out_vld_nxt;
      prod_vld_r <= prod_vld_nxt;
    end
  end

  // Payload and sequencing registers
  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    stat_r       <= stat_nxt;
    comp_r       <= comp_nxt;
    slot_r       <= slot_nxt;
    tri_ac_r     <= tri_ac_nxt;
    out_stat_r   <= out_stat_nxt;
    uu_r         <= uu_nxt;
    uv_r         <= uv_nxt;
    prod_r       <= prod_nxt;
    prod_first_r <= prod_first_nxt;
    prod_hi_r    <= prod_hi_nxt;
    acc_r        <= acc_nxt;
    for (int i = 0; i < 3; i++) begin
      a_r[i]       <= a_nxt[i];
      sp1_r[i]     <= sp1_nxt[i];
      sp2_r[i]     <= sp2_nxt[i];
      sp3_r[i]     <= sp3_nxt[i];
      ao_r[i]      <= ao_nxt[i];
      ab_r[i]      <= ab_nxt[i];
      ac_r[i]      <= ac_nxt[i];
      ad_r[i]      <= ad_nxt[i];
      abc_r[i]     <= abc_nxt[i];
      n_r[i]       <= n_nxt[i];
      p_r[i]       <= p_nxt[i];
      dir_r[i]     <= dir_nxt[i];
      out_dir_r[i] <= out_dir_nxt[i];
    end
  end

endmodule

`default_nettype wire

// ----- sim/gjk_tb_if.sv -----
`timescale 1ns / 100ps
`default_nettype none

// Channels come from the RTL interface files; this file carries only
// the testbench-side helpers for one support-point item and its result.
package gjk_tb_pkg;
  import gjk_pkg::*;

  typedef struct packed {
    logic                   start_query;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic signed [PT_W-1:0] pz;
  } point_item_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
    logic [STAT_W-1:0]       st;
  } dir_result_t;
endpackage

`default_nettype wire

// ----- sim/gjk_simplex_intersection_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module gjk_simplex_intersection_tb;
  import gjk_pkg::*;
  import gjk_tb_pkg::*;

  typedef logic signed [63:0]  s64_t;
  typedef logic signed [127:0] s128_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  gjk_in_if  in_ch ();
  gjk_out_if out_ch ();

  gjk_simplex_intersection dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  s64_t   simp [4][3];
  s64_t   sdir [3];
  phase_t ph;

  dir_result_t expected_dirs[$];
  int          errors;
  int          n_sent, n_got, n_hit, n_sep;

  function automatic s128_t dot3(input s64_t a[3], input s64_t b[3]);
    return s128_t'(a[0]) * b[0] + s128_t'(a[1]) * b[1] + s128_t'(a[2]) * b[2];
  endfunction

  function automatic void cross3(output s64_t r[3], input s64_t a[3], input s64_t b[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // (u x v) x u
  function automatic void triple(output s64_t r[3], input s64_t u[3], input s64_t v[3]);
    s64_t uu, uv;
    uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    for (int i = 0; i < 3; i++) r[i] = v[i] * uu - u[i] * uv;
  endfunction

  // Face edge tests; true when cut back to a line
  function automatic bit face_edges(input s64_t ab[3], input s64_t ac[3], input s64_t abc[3],
                                    input s64_t ao[3], input s64_t a[3]);
    s64_t p[3];
    cross3(p, ab, abc);
    if (dot3(p, ao) > 0) begin
      simp[2] = simp[1];
      simp[1] = a;
      triple(sdir, ab, ao);
      ph = PH_LINE;
      return 1'b1;
    end
    cross3(p, abc, ac);
    if (dot3(p, ao) > 0) begin
      simp[1] = a;
      triple(sdir, ac, ao);
      ph = PH_LINE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void keep_face(input s64_t abc[3], input s64_t a[3]);
    simp[3] = simp[2];
    simp[2] = simp[1];
    simp[1] = a;
    sdir = abc;
    ph = PH_TRI;
  endfunction

  // One simplex step; true when the origin is enclosed
  function automatic bit simplex_step(input s64_t a[3]);
    s64_t ao[3], ab[3], ac[3], ad[3], abc[3], n[3];
    for (int i = 0; i < 3; i++) begin
      ao[i] = -a[i];
      ab[i] = simp[1][i] - a[i];
      ac[i] = simp[2][i] - a[i];
    end
    cross3(abc, ab, ac);
    if (ph == PH_LINE) begin
      if (face_edges(ab, ac, abc, ao, a)) return 1'b0;
      if (dot3(abc, ao) > 0) keep_face(abc, a);
      else begin
        simp[3] = simp[1];
        simp[1] = a;
        for (int i = 0; i < 3; i++) sdir[i] = -abc[i];
        ph = PH_TRI;
      end
      return 1'b0;
    end
    if (!(dot3(abc, ao) > 0)) begin
      for (int i = 0; i < 3; i++) ad[i] = simp[3][i] - a[i];
      cross3(n, ac, ad);
      if (dot3(n, ao) > 0) begin
        simp[1] = simp[2];
        simp[2] = simp[3];
        ab = ac; ac = ad; abc = n;
      end else begin
        cross3(n, ad, ab);
        if (dot3(n, ao) > 0) begin
          simp[2] = simp[1];
          simp[1] = simp[3];
          ac = ab; ab = ad; abc = n;
        end else begin
          simp[0] = a;
          return 1'b1;
        end
      end
    end
    if (!face_edges(ab, ac, abc, ao, a)) keep_face(abc, a);
    return 1'b0;
  endfunction

  function automatic dir_result_t next_direction(input point_item_t it);
    s64_t a[3], t[3], na[3];
    status_t st;
    dir_result_t r;
    a[0] = it.px; a[1] = it.py; a[2] = it.pz;
    if (it.start_query) begin
      sdir[0] = 1; sdir[1] = 0; sdir[2] = 0;
      if (a[0] < 0) begin
        ph = PH_IDLE; st = ST_SEP;
      end else begin
        simp[2] = a;
        for (int i = 0; i < 3; i++) sdir[i] = -a[i];
        ph = PH_ONE; st = ST_CONT;
      end
    end else if (ph == PH_IDLE) begin
      st = ST_NOQ;
    end else if (dot3(a, sdir) < 0) begin
      ph = PH_IDLE; st = ST_SEP;
    end else if (ph == PH_ONE) begin
      simp[1] = a;
      for (int i = 0; i < 3; i++) begin
        t[i] = simp[2][i] - a[i];
        na[i] = -a[i];
      end
      triple(sdir, t, na);
      ph = PH_LINE; st = ST_CONT;
    end else if (simplex_step(a)) begin
      ph = PH_IDLE; st = ST_HIT;
    end else begin
      st = ST_CONT;
    end
    r.st = st;
    r.dx = (st == ST_CONT) ? sdir[0][DIR_W-1:0] : '0;
    r.dy = (st == ST_CONT) ? sdir[1][DIR_W-1:0] : '0;
    r.dz = (st == ST_CONT) ? sdir[2][DIR_W-1:0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Idling control: no idling for a long stretch in the middle of the run
  bit no_idle;
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 21);
  endfunction

  // Sender: one item per call, waits for acceptance; valid drops only to idle
  task automatic send_point(input point_item_t it);
    if (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_query <= it.start_query;
    in_ch.point_x     <= it.px;
    in_ch.point_y     <= it.py;
    in_ch.point_z     <= it.pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_dirs.push_back(next_direction(it));
    n_sent++;
  endtask

  // Receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        dir_result_t e;
        n_got++;
        if (expected_dirs.size() == 0) report_mismatch("result with nothing expected");
        else begin
          e = expected_dirs.pop_front();
          if (out_ch.status != e.st)
            report_mismatch($sformatf("status %0d want %0d", out_ch.status, e.st));
          if (out_ch.dir_x != e.dx)
            report_mismatch($sformatf("dir_x %0d want %0d", out_ch.dir_x, e.dx));
          if (out_ch.dir_y != e.dy)
            report_mismatch($sformatf("dir_y %0d want %0d", out_ch.dir_y, e.dy));
          if (out_ch.dir_z != e.dz)
            report_mismatch($sformatf("dir_z %0d want %0d", out_ch.dir_z, e.dz));
          if (e.st == ST_HIT) n_hit++;
          if (e.st == ST_SEP) n_sep++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving
  localparam int STALL_LIMIT = 20000;
  int quiet;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d results pending", expected_dirs.size());
      $display("gjk_simplex_intersection_tb: FAIL");
      $finish;
    end
  end

  // Directed stimulus; status typed where it is obvious, else predicted
  typedef struct {
    point_item_t it;
    bit          has_want;
    status_t     want;
  } row_t;

  localparam int N_ROWS = 20;
  row_t rows[N_ROWS] = '{
    '{'{1'b0, 16'sd5, 16'sd5, 16'sd5}, 1'b1, ST_NOQ},          // no query after reset
    '{'{1'b1, -16'sd1, 16'sd0, 16'sd0}, 1'b1, ST_SEP},         // start with x < 0
    '{'{1'b1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ST_CONT},         // start at origin
    '{'{1'b0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ST_CONT},         // zero direction goes on
    '{'{1'b1, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, ST_CONT},
    '{'{1'b0, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, ST_CONT},
    '{'{1'b0, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, ST_CONT},
    '{'{1'b0, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, ST_CONT},
    '{'{1'b1, 16'sd10, 16'sd0, 16'sd0}, 1'b0, ST_CONT},         // tetrahedron around origin
    '{'{1'b0, -16'sd10, 16'sd1, 16'sd0}, 1'b0, ST_CONT},
    '{'{1'b0, 16'sd0, 16'sd10, 16'sd1}, 1'b0, ST_CONT},
    '{'{1'b0, 16'sd0, -16'sd10, 16'sd10}, 1'b0, ST_CONT},
    '{'{1'b0, 16'sd0, 16'sd0, -16'sd10}, 1'b0, ST_CONT},
    '{'{1'b1, 16'sd100, 16'sd100, 16'sd100}, 1'b0, ST_CONT},    // far shape, separation
    '{'{1'b0, 16'sd100, 16'sd100, 16'sd100}, 1'b1, ST_SEP},
    '{'{1'b0, 16'sd1, 16'sd1, 16'sd1}, 1'b1, ST_NOQ},           // idle after end of query
    '{'{1'b1, 16'sd7, -16'sd3, 16'sd2}, 1'b0, ST_CONT},
    '{'{1'b1, 16'sd9, 16'sd4, -16'sd4}, 1'b0, ST_CONT},         // restart mid query
    '{'{1'b0, -16'sd9, -16'sd4, 16'sd4}, 1'b0, ST_CONT},
    '{'{1'b0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ST_CONT}
  };

  // Random point, mostly small, sometimes full range
  function automatic logic signed [PT_W-1:0] rnd_coord();
    if ($urandom_range(9) == 0) return PT_W'($urandom);
    return PT_W'($signed($urandom_range(400)) - 200);
  endfunction

  // Point on the far side of the current direction, small offsets
  function automatic point_item_t follow_dir();
    point_item_t it;
    s64_t m;
    it.start_query = 1'b0;
    m = 1;
    for (int i = 0; i < 3; i++) begin
      if (sdir[i] > m || -sdir[i] > m) m = (sdir[i] < 0) ? -sdir[i] : sdir[i];
    end
    it.px = PT_W'((sdir[0] * 150) / m) + PT_W'($signed($urandom_range(20)) - 10);
    it.py = PT_W'((sdir[1] * 150) / m) + PT_W'($signed($urandom_range(20)) - 10);
    it.pz = PT_W'((sdir[2] * 150) / m) + PT_W'($signed($urandom_range(20)) - 10);
    return it;
  endfunction

  initial begin
    point_item_t it;
    int k;
    in_ch.valid = 1'b0;
    in_ch.start_query = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    no_idle = 1'b0;
    for (int i = 0; i < 4; i++) for (int j = 0; j < 3; j++) simp[i][j] = 0;
    for (int j = 0; j < 3; j++) sdir[j] = 0;
    ph = PH_IDLE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (rows[r]) begin
      send_point(rows[r].it);
      if (rows[r].has_want && expected_dirs[$].st != rows[r].want)
        report_mismatch($sformatf("row %0d: predicted status differs from table", r));
    end

    // Random queries: mostly well-formed, some noise
    k = 0;
    while (k < 1400) begin
      no_idle = (k >= 500 && k < 700);
      if (ph == PH_IDLE || $urandom_range(19) == 0) begin
        it.start_query = 1'b1;
        it.px = ($urandom_range(7) == 0) ? -rnd_coord() : rnd_coord();
        it.py = rnd_coord();
        it.pz = rnd_coord();
        if ($urandom_range(15) == 0) it.start_query = 1'b0;
      end else if ($urandom_range(5) == 0) begin
        it.start_query = 1'b0;
        it.px = rnd_coord(); it.py = rnd_coord(); it.pz = rnd_coord();
      end else begin
        it = follow_dir();
      end
      send_point(it);
      k++;
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain
    k = 0;
    while (expected_dirs.size() != 0 && k < 50000) begin
      @(posedge clk);
      k++;
    end
    repeat (200) @(posedge clk);

    $display("covered %0d support points, %0d results: %0d intersecting, %0d separated",
             n_sent, n_got, n_hit, n_sep);
    if (errors == 0 && expected_dirs.size() == 0) begin
      $display("gjk_simplex_intersection_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_dirs.size());
      $display("gjk_simplex_intersection_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/gjk_pkg.sv
rtl/core/gjk_in_if.sv
rtl/core/gjk_out_if.sv
rtl/core/gjk_simplex_intersection.sv
sim/gjk_tb_if.sv
sim/gjk_simplex_intersection_tb.sv
